[design/assert_macros.svh]
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");

`define CHK_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");

`endif

[design/scfl_pkg.sv]
package scfl_pkg;

    localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
    localparam int HASH_SHIFT = 52;

    typedef enum logic [2:0] {
        OUT_SERVED    = 3'd0,
        OUT_NEW_CLASS = 3'd1,
        OUT_EMPTY     = 3'd2,
        OUT_NO_CLASS  = 3'd3,
        OUT_POOLED    = 3'd4,
        OUT_RELEASED  = 3'd5
    } t_outcome;

    typedef struct packed {
        logic        kind;
        logic [31:0] size_bytes;
        logic [47:0] block_address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [47:0] served_address;
    } t_out_item;

    // front to back: classified item
    typedef struct packed {
        logic        kind;
        logic [31:0] size_bytes;
        logic [47:0] block_address;
        logic [11:0] home;
    } t_cmd;

endpackage

[design/scfl_front.sv]
module scfl_front #(
    parameter int INDEX_SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  scfl_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop,
    output scfl_pkg::t_cmd    o_cmd
);
    import scfl_pkg::*;

    localparam logic [11:0] HMASK = 12'(INDEX_SLOTS - 1);

    // stage 1: item and partial hash products, stage 2: home slot, then 2-entry queue
    logic      r_s1_v, r_s2_v;
    t_in_item  r_s1;
    t_cmd      r_s2;
    logic [63:0] w_plo;
    logic [31:0] w_phi;
    logic [31:0] r_plo_hi, r_phi;
    logic [31:0] w_hsum;
    t_cmd      r_q [2];
    logic      r_wp, r_rp;
    logic [1:0] r_cnt;
    logic      w_enq, w_deq, w_s2_adv, w_s1_adv;

    assign w_deq = i_cmd_pop && (r_cnt != 2'd0);
    assign w_enq = r_s2_v && ((r_cnt != 2'd2) || w_deq);
    assign w_s2_adv = !r_s2_v || w_enq;
    assign w_s1_adv = !r_s1_v || w_s2_adv;
    assign o_full = !w_s1_adv;
    // low 64 bits of size * HASH_MULT from two 32x32 products
    assign w_plo = {32'd0, i_item.size_bytes} * {32'd0, HASH_MULT[31:0]};
    assign w_phi = i_item.size_bytes * HASH_MULT[63:32];
    assign w_hsum = r_plo_hi + r_phi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_s1_adv) begin
                r_s1_v <= i_push;
                r_s1 <= i_item;
                r_plo_hi <= w_plo[63:32];
                r_phi <= w_phi;
            end
            if (w_s2_adv) begin
                r_s2_v <= r_s1_v;
                r_s2.kind <= r_s1.kind;
                r_s2.size_bytes <= r_s1.size_bytes;
                r_s2.block_address <= r_s1.block_address;
                r_s2.home <= w_hsum[31:20] & HMASK;
            end
            if (w_enq) begin
                r_q[r_wp] <= r_s2;
                r_wp <= !r_wp;
            end
            if (w_deq) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_enq) - 2'(w_deq);
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];
endmodule

[design/scfl_back.sv]
module scfl_back #(
    parameter int INDEX_SLOTS   = 64,
    parameter int PER_CLASS_CAP = 128,
    parameter int INITIAL_CAP   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    input  scfl_pkg::t_cmd     i_cmd,
    output logic               o_empty,
    input  logic               i_pop,
    output scfl_pkg::t_out_item o_item
);
    import scfl_pkg::*;

    localparam int SW = (INDEX_SLOTS > 1) ? $clog2(INDEX_SLOTS) : 1;
    localparam int MAXC = INDEX_SLOTS / 2;
    localparam int CW = (MAXC > 1) ? $clog2(MAXC) : 1;
    localparam int CNTW = $clog2(MAXC + 1);
    localparam int FW = $clog2(PER_CLASS_CAP + 1);
    localparam int PW = (PER_CLASS_CAP > 1) ? $clog2(PER_CLASS_CAP) : 1;
    localparam int AW = CW + PW;
    localparam int NCAP = (INITIAL_CAP < PER_CLASS_CAP) ? INITIAL_CAP : PER_CLASS_CAP;
    localparam logic [SW-1:0] SMASK = SW'(INDEX_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_PROBE, S_CLASS, S_ACT, S_READ, S_OUT
    } t_state;

    t_state r_state;
    // slot valid bits stand in for the all-zero key reset
    logic [INDEX_SLOTS-1:0] r_kv;
    logic [31:0] r_key [INDEX_SLOTS];
    logic [CW-1:0] r_cls [INDEX_SLOTS];
    logic [FW-1:0] r_fill [MAXC];
    logic [FW-1:0] r_capm [MAXC];
    logic [47:0] r_pool [MAXC << PW];
    logic [CNTW-1:0] r_ccount;

    t_cmd r_cmd;
    logic [SW-1:0] r_slot;
    logic [12:0] r_n;
    logic [31:0] r_kd;
    logic r_kdv;
    logic [CW-1:0] r_c, r_cd;
    logic [FW-1:0] r_f, r_cp;
    logic [47:0] r_rd;
    logic [AW-1:0] r_adr;
    logic r_ov;
    t_out_item r_out;
    logic [FW:0] w_dbl;
    logic [FW-1:0] w_cap2;

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid && !r_ov;
    assign o_empty = !r_ov;
    assign o_item = r_out;
    assign w_dbl = {r_cp, 1'b0};
    assign w_cap2 = (w_dbl > (FW+1)'(PER_CLASS_CAP)) ? FW'(PER_CLASS_CAP) : FW'(w_dbl);

    always_ff @(posedge i_clk) begin
        r_kd <= r_key[r_slot];
        r_cd <= r_cls[r_slot];
        r_rd <= r_pool[r_adr];
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kv <= '0;
            r_ccount <= '0;
            r_ov <= 1'b0;
        end else begin
            if (i_pop && r_ov) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd <= i_cmd;
                        r_slot <= SW'(i_cmd.home) & SMASK;
                        r_n <= '0;
                        r_state <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    // wait for the registered key read
                    r_kdv <= r_kv[r_slot];
                    r_state <= S_CLASS;
                end
                S_CLASS: begin
                    if (r_cmd.size_bytes == 32'd0) begin
                        r_out <= {(r_cmd.kind ? OUT_RELEASED : OUT_NO_CLASS), 48'd0};
                        r_state <= S_OUT;
                    end else if (!r_kdv) begin
                        if (r_cmd.kind || r_ccount >= CNTW'(MAXC)) begin
                            r_out <= {(r_cmd.kind ? OUT_RELEASED : OUT_NO_CLASS), 48'd0};
                        end else begin
                            r_kv[r_slot] <= 1'b1;
                            r_key[r_slot] <= r_cmd.size_bytes;
                            r_cls[r_slot] <= CW'(r_ccount);
                            r_fill[CW'(r_ccount)] <= '0;
                            r_capm[CW'(r_ccount)] <= FW'(NCAP);
                            r_ccount <= r_ccount + 1'b1;
                            r_out <= {OUT_NEW_CLASS, 48'd0};
                        end
                        r_state <= S_OUT;
                    end else if (r_kd == r_cmd.size_bytes) begin
                        r_c <= r_cd;
                        r_f <= r_fill[r_cd];
                        r_cp <= r_capm[r_cd];
                        r_state <= S_ACT;
                    end else if (r_n == 13'(INDEX_SLOTS - 1)) begin
                        r_out <= {(r_cmd.kind ? OUT_RELEASED : OUT_NO_CLASS), 48'd0};
                        r_state <= S_OUT;
                    end else begin
                        r_n <= r_n + 1'b1;
                        r_slot <= (r_slot + 1'b1) & SMASK;
                        r_state <= S_PROBE;
                    end
                end
                S_ACT: begin
                    if (!r_cmd.kind) begin
                        if (r_f >= r_cp && r_cp < FW'(PER_CLASS_CAP))
                            r_capm[r_c] <= w_cap2;
                        if (r_f == '0) begin
                            r_out <= {OUT_EMPTY, 48'd0};
                            r_state <= S_OUT;
                        end else begin
                            r_fill[r_c] <= r_f - 1'b1;
                            r_adr <= {r_c, PW'(r_f - 1'b1)};
                            r_state <= S_READ;
                        end
                    end else begin
                        if (r_f < r_cp && r_f < FW'(PER_CLASS_CAP)) begin
                            r_pool[{r_c, PW'(r_f)}] <= r_cmd.block_address;
                            r_fill[r_c] <= r_f + 1'b1;
                            r_out <= {OUT_POOLED, 48'd0};
                        end else begin
                            r_out <= {OUT_RELEASED, 48'd0};
                        end
                        r_state <= S_OUT;
                    end
                end
                S_READ: begin
                    // pool read data lands this cycle
                    r_state <= S_OUT;
                    r_out <= {OUT_SERVED, 48'd0};
                    r_n <= 13'h1fff;
                end
                S_OUT: begin
                    if (r_n == 13'h1fff) r_out.served_address <= r_rd;
                    r_ov <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[design/size_class_free_list_pool_unit.sv]
// channel  | direction | handshake      | payload
// request  | in        | push/full      | i_item (kind, size_bytes, block_address)
// result   | out       | empty/pop      | o_item (outcome, served_address)
// Front: item and partial hash products, then home slot, into a two-entry command queue;
// an idle front passes an accepted item through stage 1, stage 2 and the queue to the back.
// Back: one command at a time; each probed slot takes S_PROBE and S_CLASS, then a hit goes
// through S_ACT (and S_READ for a served take) and S_OUT raises the result.
// Synchronous reset clears slot valid bits and class count; no clearing pass.
// The back stops taking commands while a result waits for pop.
`include "assert_macros.svh"
module size_class_free_list_pool_unit #(
    parameter int INDEX_SLOTS   = 64,
    parameter int PER_CLASS_CAP = 128,
    parameter int INITIAL_CAP   = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  scfl_pkg::t_in_item i_item,
    output logic               empty,
    input  logic               pop,
    output scfl_pkg::t_out_item o_item
);
    import scfl_pkg::*;

    logic l_cv, l_cp;
    t_cmd l_cmd;

    scfl_front #(.INDEX_SLOTS(INDEX_SLOTS)) u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_item,
        .o_cmd_valid(l_cv), .i_cmd_pop(l_cp), .o_cmd(l_cmd)
    );

    scfl_back #(
        .INDEX_SLOTS(INDEX_SLOTS), .PER_CLASS_CAP(PER_CLASS_CAP),
        .INITIAL_CAP(INITIAL_CAP)
    ) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(l_cv), .o_cmd_pop(l_cp), .i_cmd(l_cmd),
        .o_empty(empty), .i_pop(pop), .o_item
    );

    `CHK_IMPL(a_pop_needs_cmd, i_clk, i_rst_n, l_cp, l_cv)
    `CHK_IMPL(a_pop_when_free, i_clk, i_rst_n, l_cp, empty)
    `CHK_IMPL(a_outcome_range, i_clk, i_rst_n, !empty, o_item.outcome <= OUT_RELEASED)
    `CHK_IMPL(a_addr_zero, i_clk, i_rst_n,
        !empty && o_item.outcome != OUT_SERVED, o_item.served_address == 48'd0)
endmodule
